// ===== src/fixed_partition_fit_allocator_defines.svh =====
// Assertion macros shared by the fixed partition fit allocator.
`ifndef FIXED_PARTITION_FIT_ALLOCATOR_DEFINES_SVH
`define FIXED_PARTITION_FIT_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define FPFA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define FPFA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/fpfa_pkg.sv =====
// Shared constants, codes and control types of the fixed partition fit allocator.
package fpfa_pkg;

  localparam int BLOCKS_DEF    = 16;
  localparam int SIZE_BITS_DEF = 16;

  localparam int FUNC_W     = 1;
  localparam int SLOT_W     = 4;
  localparam int LSIZE_W    = 16;
  localparam int REQ_W      = 16;
  localparam int GBLOCK_W   = 4;
  localparam int MODE_W     = 2;
  localparam int BCOUNT_W   = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 5;

  localparam logic [FUNC_W-1:0] FUNC_LOAD  = 1'b0;
  localparam logic [FUNC_W-1:0] FUNC_ALLOC = 1'b1;

  localparam logic [MODE_W-1:0] MODE_FIRST = 2'd0;
  localparam logic [MODE_W-1:0] MODE_BEST  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_WORST = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_FIT_MODE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_COUNT = 2'd1;

  typedef struct packed {
    logic load_en;
    logic start;
    logic scan_en;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic scan_done;
  } status_t;

endpackage

// ===== src/fpfa_ifs.sv =====
// Valid/ready channel interfaces for the input, result and configuration items.
interface fpfa_in_if;
  logic                                valid;
  logic                                ready;
  logic [fpfa_pkg::FUNC_W-1:0]         func;
  logic [fpfa_pkg::SLOT_W-1:0]         slot_index;
  logic [fpfa_pkg::LSIZE_W-1:0]        load_size;
  logic [fpfa_pkg::REQ_W-1:0]          request_size;

  modport source (output valid, func, slot_index, load_size, request_size, input ready);
  modport sink   (input valid, func, slot_index, load_size, request_size, output ready);
endinterface

interface fpfa_out_if;
  logic                                valid;
  logic                                ready;
  logic                                request_granted;
  logic [fpfa_pkg::GBLOCK_W-1:0]       granted_block;

  modport source (output valid, request_granted, granted_block, input ready);
  modport sink   (input valid, request_granted, granted_block, output ready);
endinterface

interface fpfa_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [fpfa_pkg::CFG_IDX_W-1:0]      index;
  logic [fpfa_pkg::CFG_DATA_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== src/fpfa_ctrl.sv =====
// Controller state machine that sequences loads, partition scans and result hand-off.
module fpfa_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic [fpfa_pkg::FUNC_W-1:0]   in_func,
  output logic                          in_ready,
  input  logic                          out_ready,
  output logic                          out_valid,
  input  fpfa_pkg::status_t             status,
  output fpfa_pkg::cmd_t                cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_COMMIT
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r & ~out_ready;
    cmd           = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_func == fpfa_pkg::FUNC_LOAD) begin
            cmd.load_en = 1'b1;
          end else begin
            cmd.start = 1'b1;
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        cmd.scan_en = 1'b1;
        if (status.scan_done) begin
          state_nxt = S_COMMIT;
        end
      end
      S_COMMIT: begin
        if (!out_valid_r || out_ready) begin
          cmd.commit    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

endmodule

// ===== src/fpfa_dp.sv =====
// Datapath with the partition size memory, used flags, scan counter and fit selection.
module fpfa_dp #(
  parameter int BLOCKS    = fpfa_pkg::BLOCKS_DEF,
  parameter int SIZE_BITS = fpfa_pkg::SIZE_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  fpfa_pkg::cmd_t                  cmd,
  input  logic [fpfa_pkg::SLOT_W-1:0]     slot_index,
  input  logic [fpfa_pkg::LSIZE_W-1:0]    load_size,
  input  logic [fpfa_pkg::REQ_W-1:0]      request_size,
  input  logic [fpfa_pkg::MODE_W-1:0]     fit_mode,
  input  logic [fpfa_pkg::BCOUNT_W-1:0]   block_count,
  output fpfa_pkg::status_t               status,
  output logic                            request_granted,
  output logic [fpfa_pkg::GBLOCK_W-1:0]   granted_block
);

  localparam int IDX_W = (BLOCKS > 1) ? $clog2(BLOCKS) : 1;
  localparam int CNT_W = $clog2(BLOCKS + 1);
  localparam int CMP_W = (SIZE_BITS > fpfa_pkg::REQ_W) ? SIZE_BITS : fpfa_pkg::REQ_W;
  localparam int SLX_W = (IDX_W > fpfa_pkg::SLOT_W) ? IDX_W : fpfa_pkg::SLOT_W;
  localparam int PKX_W = IDX_W + fpfa_pkg::GBLOCK_W;

  logic [SIZE_BITS-1:0] size_mem [BLOCKS];
  logic [SIZE_BITS-1:0] rd_data_r;
  logic [BLOCKS-1:0]    loaded_r;
  logic [BLOCKS-1:0]    used_r;

  logic [fpfa_pkg::REQ_W-1:0]    request_r;
  logic [fpfa_pkg::MODE_W-1:0]   mode_r;
  logic [CNT_W-1:0]              limit_r, limit_nxt;
  logic [CNT_W-1:0]              cnt_r;
  logic                          chk_vld_r;
  logic [IDX_W-1:0]              chk_idx_r;
  logic                          found_r;
  logic [IDX_W-1:0]              pick_r;
  logic [SIZE_BITS-1:0]          best_r;
  logic                          granted_r;
  logic [fpfa_pkg::GBLOCK_W-1:0] block_r;

  logic [SLX_W-1:0]     slot_ext;
  logic [IDX_W-1:0]     wr_idx;
  logic                 slot_ok;
  logic                 load_we;
  logic [IDX_W-1:0]     rd_idx;
  logic                 issue;
  logic [SIZE_BITS-1:0] chk_size;
  logic                 fits;
  logic                 take;
  logic [PKX_W-1:0]     pick_ext;

  assign slot_ext = SLX_W'(slot_index);
  assign wr_idx   = slot_ext[IDX_W-1:0];
  assign slot_ok  = (32'(slot_index) < BLOCKS);
  assign load_we  = cmd.load_en & slot_ok;
  assign rd_idx   = cnt_r[IDX_W-1:0];
  assign issue    = cmd.scan_en & (cnt_r != limit_r);

  assign limit_nxt = (32'(block_count) > BLOCKS) ? CNT_W'(BLOCKS) : CNT_W'(block_count);

  assign chk_size = loaded_r[chk_idx_r] ? rd_data_r : '0;
  assign fits     = chk_vld_r & ~used_r[chk_idx_r] &
                    (CMP_W'(chk_size) >= CMP_W'(request_r));

  always_comb begin
    take = 1'b0;
    if (fits) begin
      if (!found_r) begin
        take = 1'b1;
      end else begin
        case (mode_r)
          fpfa_pkg::MODE_BEST:  take = (chk_size < best_r);
          fpfa_pkg::MODE_WORST: take = (chk_size > best_r);
          default:              take = 1'b0;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_we) begin
      size_mem[wr_idx] <= SIZE_BITS'(load_size);
    end
    rd_data_r <= size_mem[rd_idx];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      loaded_r  <= '0;
      used_r    <= '0;
      chk_vld_r <= 1'b0;
      found_r   <= 1'b0;
      cnt_r     <= '0;
    end else begin
      if (load_we) begin
        loaded_r[wr_idx] <= 1'b1;
        used_r[wr_idx]   <= 1'b0;
      end
      if (cmd.commit && found_r) begin
        used_r[pick_r] <= 1'b1;
      end
      if (cmd.start) begin
        cnt_r     <= '0;
        chk_vld_r <= 1'b0;
        found_r   <= 1'b0;
      end else begin
        chk_vld_r <= issue;
        if (issue) begin
          cnt_r <= cnt_r + CNT_W'(1);
        end
        if (take) begin
          found_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      request_r <= request_size;
      mode_r    <= fit_mode;
      limit_r   <= limit_nxt;
    end
    if (issue) begin
      chk_idx_r <= rd_idx;
    end
    if (take) begin
      pick_r <= chk_idx_r;
      best_r <= chk_size;
    end
    if (cmd.commit) begin
      granted_r <= found_r;
      block_r   <= found_r ? pick_ext[fpfa_pkg::GBLOCK_W-1:0] : '0;
    end
  end

  assign pick_ext         = PKX_W'(pick_r);
  assign status.scan_done = (cnt_r == limit_r) & ~chk_vld_r;
  assign request_granted  = granted_r;
  assign granted_block    = block_r;

endmodule

// ===== src/fixed_partition_fit_allocator.sv =====
// An allocate item scans min(block_count, BLOCKS) entries of the partition size memory,
// one entry per cycle through its registered read port; the last compare and then the
// commit follow before a result is offered. Partitions never loaded read as size zero.
// A finished result waits in an output register, and the next item is accepted while it
// waits; a following allocate item holds its own result until the waiting one is taken.
// Configuration writes are taken in any cycle.
module fixed_partition_fit_allocator #(
  parameter int BLOCKS    = fpfa_pkg::BLOCKS_DEF,
  parameter int SIZE_BITS = fpfa_pkg::SIZE_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  fpfa_in_if.sink     in_ch,
  fpfa_out_if.source  out_ch,
  fpfa_cfg_if.sink    cfg_ch
);

  `include "fixed_partition_fit_allocator_defines.svh"

  logic [fpfa_pkg::MODE_W-1:0]   fit_mode_r;
  logic [fpfa_pkg::BCOUNT_W-1:0] block_count_r;
  fpfa_pkg::cmd_t                cmd;
  fpfa_pkg::status_t             status;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fit_mode_r    <= fpfa_pkg::MODE_FIRST;
      block_count_r <= fpfa_pkg::BCOUNT_W'(16);
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        fpfa_pkg::CFG_FIT_MODE:    fit_mode_r    <= cfg_ch.data[fpfa_pkg::MODE_W-1:0];
        fpfa_pkg::CFG_BLOCK_COUNT: block_count_r <= cfg_ch.data[fpfa_pkg::BCOUNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  fpfa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_func   (in_ch.func),
    .in_ready  (in_ch.ready),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .status    (status),
    .cmd       (cmd)
  );

  fpfa_dp #(
    .BLOCKS    (BLOCKS),
    .SIZE_BITS (SIZE_BITS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .slot_index      (in_ch.slot_index),
    .load_size       (in_ch.load_size),
    .request_size    (in_ch.request_size),
    .fit_mode        (fit_mode_r),
    .block_count     (block_count_r),
    .status          (status),
    .request_granted (out_ch.request_granted),
    .granted_block   (out_ch.granted_block)
  );

  `FPFA_ASSERT_NOW(a_commit_no_overwrite, cmd.commit, !out_ch.valid || out_ch.ready, "result overwritten before it was taken")
  `FPFA_ASSERT_NEXT(a_busy_after_start, cmd.start, !in_ch.ready, "item accepted while a scan is running")
  `FPFA_ASSERT_NOW(a_denied_block_zero, out_ch.valid && !out_ch.request_granted, out_ch.granted_block == '0, "denied result carries a nonzero block")

endmodule
